// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache store package
// Shared sizes, the scan word that travels along the cell row and the
// update command that the controller broadcasts to the cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 32;
  localparam int TICK_W  = 64;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [DATA_W-1:0]  MISS_VALUE = '1;

  // Partial result of a lookup, refined by each cell it passes through.
  typedef struct packed {
    logic               live;
    logic [DATA_W-1:0]  key;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [DATA_W-1:0]  hit_value;
    logic               have_victim;
    logic [IDX_W-1:0]   victim_idx;
    logic [DATA_W-1:0]  victim_key;
    logic [COUNT_W-1:0] victim_count;
    logic [TICK_W-1:0]  victim_tick;
    logic               have_free;
    logic [IDX_W-1:0]   free_idx;
    logic [OCC_W-1:0]   occupied;
  } scan_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_USE  = 2'd1,
    CMD_FILL = 2'd2
  } cmd_op_t;

  // Update of one slot, applied by the cell whose index matches.
  typedef struct packed {
    cmd_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic              wr_value;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [TICK_W-1:0] tick;
  } cmd_t;

endpackage

// ===== rtl/lfu_if.sv =====
// ----------------------------------------------------------------------------
// LFU cache store channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [lfu_pkg::DATA_W-1:0] req_key;
  logic [lfu_pkg::DATA_W-1:0] write_value;

  modport source (output valid, req_type, req_key, write_value, input ready);
  modport sink   (input valid, req_type, req_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lfu_pkg::DATA_W-1:0] read_value;
  logic                       evicted;
  logic [lfu_pkg::DATA_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/lfu_cache_store_top.sv =====
// ----------------------------------------------------------------------------
// LFU cache store
// Fully associative key-value store with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Each request word is a get or a set and produces exactly one response
// word. The store is a row of ENTRIES identical cells, one slot each. A
// request launches a scan word into the first cell; every cycle it moves one
// cell further, and each cell folds its own slot into it: key match, free
// slot search, occupancy count, and the running least-frequently-used victim
// (lowest use count, then oldest last-use tick, then lowest slot). When the
// word leaves the last cell the controller decides the outcome; once the
// response register is free it loads it and sends one update command to
// the chosen cell, or none on a get miss. A request thus passes through
// every cell register and may wait on the output register before its
// response; a new request is taken once the previous one has issued its
// update, even while its response still waits in the output register. Use
// counts saturate and the 64-bit operation tick wraps. The capacity
// register may be written only while no request is in flight; a value of
// zero acts as one and a value above the row size acts as the row size.
// ----------------------------------------------------------------------------
module lfu_cache_store_top (
  input  logic                      clk,
  input  logic                      rst,
  lfu_req_if.sink                   req,
  lfu_rsp_if.source                 rsp,
  input  logic                      cfg_write_en,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_write_data
);

  // Scan words between cells: entry zero is the seed, the last is the tail.
  lfu_pkg::scan_t chain [lfu_pkg::ENTRIES+1];
  lfu_pkg::cmd_t  cmd;

  lfu_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .seed           (chain[0]),
    .tail           (chain[lfu_pkg::ENTRIES]),
    .cmd            (cmd)
  );

  // The update command is broadcast; only the addressed cell acts on it.
  for (genvar g = 0; g < lfu_pkg::ENTRIES; g++) begin : g_cell
    localparam int unsigned CellNum = g;

    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (CellNum[lfu_pkg::IDX_W-1:0]),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1]),
      .cmd      (cmd)
    );
  end

endmodule

// ===== rtl/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// LFU cache store cell
// One slot of the store. Refines the passing scan word with its own entry
// and registers it for the next cell; applies update commands for its index.
// ----------------------------------------------------------------------------
module lfu_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lfu_pkg::IDX_W-1:0] cell_idx,
  input  lfu_pkg::scan_t            scan_in,
  output lfu_pkg::scan_t            scan_out,
  input  lfu_pkg::cmd_t             cmd
);

  logic                        valid;
  logic [lfu_pkg::DATA_W-1:0]  key;
  logic [lfu_pkg::DATA_W-1:0]  value;
  logic [lfu_pkg::COUNT_W-1:0] count;
  logic [lfu_pkg::TICK_W-1:0]  last_use;

  lfu_pkg::scan_t scan_next;
  logic           older;

  always_comb begin
    scan_next = scan_in;
    older = !scan_in.have_victim || (count < scan_in.victim_count) ||
            ((count == scan_in.victim_count) && (last_use < scan_in.victim_tick));
    if (valid) begin
      scan_next.occupied = scan_in.occupied + lfu_pkg::OCC_W'(1);
      if (!scan_in.hit && (key == scan_in.key)) begin
        scan_next.hit       = 1'b1;
        scan_next.hit_idx   = cell_idx;
        scan_next.hit_value = value;
      end
      if (older) begin
        scan_next.have_victim  = 1'b1;
        scan_next.victim_idx   = cell_idx;
        scan_next.victim_key   = key;
        scan_next.victim_count = count;
        scan_next.victim_tick  = last_use;
      end
    end else if (!scan_in.have_free) begin
      scan_next.have_free = 1'b1;
      scan_next.free_idx  = cell_idx;
    end
  end

  // The live flag is control; the rest of the word rides along unreset.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.live <= 1'b0;
    end else begin
      scan_out.live <= scan_next.live;
    end
    scan_out.key          <= scan_next.key;
    scan_out.hit          <= scan_next.hit;
    scan_out.hit_idx      <= scan_next.hit_idx;
    scan_out.hit_value    <= scan_next.hit_value;
    scan_out.have_victim  <= scan_next.have_victim;
    scan_out.victim_idx   <= scan_next.victim_idx;
    scan_out.victim_key   <= scan_next.victim_key;
    scan_out.victim_count <= scan_next.victim_count;
    scan_out.victim_tick  <= scan_next.victim_tick;
    scan_out.have_free    <= scan_next.have_free;
    scan_out.free_idx     <= scan_next.free_idx;
    scan_out.occupied     <= scan_next.occupied;
  end

  logic selected;
  assign selected = (cmd.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (selected && (cmd.op == lfu_pkg::CMD_FILL)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (selected) begin
      unique case (cmd.op)
        lfu_pkg::CMD_USE: begin
          if (count != lfu_pkg::COUNT_MAX) begin
            count <= count + lfu_pkg::COUNT_W'(1);
          end
          last_use <= cmd.tick;
          if (cmd.wr_value) begin
            value <= cmd.value;
          end
        end
        lfu_pkg::CMD_FILL: begin
          key      <= cmd.key;
          value    <= cmd.value;
          count    <= lfu_pkg::COUNT_W'(1);
          last_use <= cmd.tick;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// LFU cache store controller
// Accepts requests, launches the scan word down the cell row, turns the
// finished scan into a slot update and a response word.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  lfu_req_if.sink                   req,
  lfu_rsp_if.source                 rsp,
  input  logic                      cfg_write_en,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_write_data,
  output lfu_pkg::scan_t            seed,
  input  lfu_pkg::scan_t            tail,
  output lfu_pkg::cmd_t             cmd
);

  localparam int EffW = (lfu_pkg::OCC_W > lfu_pkg::CAP_W) ? lfu_pkg::OCC_W : lfu_pkg::CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [lfu_pkg::CAP_W-1:0]  capacity;
  logic [lfu_pkg::TICK_W-1:0] op_tick;
  logic                       is_set;
  logic [lfu_pkg::DATA_W-1:0] set_value;
  lfu_pkg::scan_t             result;

  logic accept;
  logic fire;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    seed      = '0;
    seed.live = accept;
    seed.key  = req.req_key;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (tail.live) state_next = S_DONE;
      S_DONE: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= lfu_pkg::CAP_RESET;
      op_tick  <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (accept) begin
        op_tick <= op_tick + lfu_pkg::TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_set    <= req.req_type;
      set_value <= req.write_value;
    end
    if ((state == S_SCAN) && tail.live) begin
      result <= tail;
    end
  end

  // Effective capacity: zero acts as one, anything above the row as the row.
  logic [EffW-1:0] cap_ext, eff_cap, occ_ext;
  logic            do_evict;

  always_comb begin
    cap_ext = EffW'(capacity);
    occ_ext = EffW'(result.occupied);
    if (capacity == '0) begin
      eff_cap = EffW'(1);
    end else if (cap_ext > EffW'(lfu_pkg::ENTRIES)) begin
      eff_cap = EffW'(lfu_pkg::ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    do_evict = is_set && !result.hit && result.have_victim &&
               ((occ_ext >= eff_cap) || !result.have_free);
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = lfu_pkg::CMD_NONE;
    cmd.key      = result.key;
    cmd.value    = set_value;
    cmd.tick     = op_tick;
    cmd.wr_value = is_set;
    cmd.idx      = result.hit_idx;
    if (fire) begin
      if (result.hit) begin
        cmd.op = lfu_pkg::CMD_USE;
      end else if (is_set) begin
        cmd.op  = lfu_pkg::CMD_FILL;
        cmd.idx = do_evict ? result.victim_idx : result.free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.hit         <= result.hit;
      rsp.evicted     <= do_evict;
      rsp.evicted_key <= do_evict ? result.victim_key : '0;
      if (is_set) begin
        rsp.read_value <= '0;
      end else if (result.hit) begin
        rsp.read_value <= result.hit_value;
      end else begin
        rsp.read_value <= lfu_pkg::MISS_VALUE;
      end
    end
  end

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.live |-> (state == S_SCAN))
    else $error("scan word left the row outside a lookup");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN))
    else $error("accepted request did not start a scan");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("response raised without a finished scan");

  a_tick_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(op_tick))
    else $error("operation tick moved without a request");

  a_evict_only_set_miss: assert property (@(posedge clk) disable iff (rst)
    (fire && do_evict) |-> (is_set && !result.hit && (cmd.op == lfu_pkg::CMD_FILL)))
    else $error("eviction outside a set miss");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// LFU cache store testbench
// Drives get and set words into the store, predicts every response word from
// its own copy of the slots, tick and capacity, and checks each response field
// by field under several capacity settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Request kinds as carried on req_type.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } req_op_t;

  // One response word as the store should produce it.
  typedef struct packed {
    logic                       hit;
    logic [lfu_pkg::DATA_W-1:0] read_value;
    logic                       evicted;
    logic [lfu_pkg::DATA_W-1:0] evicted_key;
  } access_result_t;

  // Quiet time after the last response, sized from the length of the cell
  // row, so that the store is left idle.
  localparam int PIPE_LAT = lfu_pkg::ENTRIES + 2;

  // The slowest correct run is roughly 1370 words, plus random gaps and
  // stalls and one long receiver hold; the limit leaves a wide margin over
  // that.
  localparam int LIMIT_CYCLES = 500_000;

  // Length of the deliberate receiver hold, long enough for the store to
  // fill and push back on its request channel.
  localparam int LONG_HOLD = 400;

  localparam logic [lfu_pkg::DATA_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [lfu_pkg::DATA_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [lfu_pkg::DATA_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

  localparam int POOL_SIZE = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write_en;
  logic [lfu_pkg::CAP_W-1:0] cfg_write_data;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_cache_store_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted store state. Only slots marked in use are ever looked at, so
  // the contents of empty slots never matter.
  // --------------------------------------------------------------------------
  bit                          slot_used  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]  slot_key   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]  slot_val   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_W-1:0] slot_uses  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::TICK_W-1:0]  slot_stamp [lfu_pkg::ENTRIES];
  logic [lfu_pkg::TICK_W-1:0]  tick_now;
  logic [lfu_pkg::CAP_W-1:0]   cap_reg;

  access_result_t due_responses [$];
  logic [lfu_pkg::DATA_W-1:0] key_pool [POOL_SIZE];

  int          mismatch_count = 0;
  int          rsp_seen = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left;
  int unsigned cycle_count;

  // A hit counts as one more use: the count saturates rather than wrapping
  // and the slot is stamped with the current tick.
  function automatic void note_use(int s);
    if (slot_uses[s] != lfu_pkg::COUNT_MAX) slot_uses[s] = slot_uses[s] + 1'b1;
    slot_stamp[s] = tick_now;
  endfunction

  // Apply one request to the predicted state and return the response word it
  // should produce.
  function automatic access_result_t lfu_access(logic is_set,
                                                logic [lfu_pkg::DATA_W-1:0] key,
                                                logic [lfu_pkg::DATA_W-1:0] val);
    access_result_t r;
    int found, victim, free_idx, occupied, cap_eff, target;
    bit hit, have_free, have_victim;
    r = '0;
    found = 0;
    victim = 0;
    free_idx = 0;
    occupied = 0;
    hit = 1'b0;
    have_free = 1'b0;
    have_victim = 1'b0;
    tick_now = tick_now + 1'b1;

    // A capacity of zero behaves as one, anything above the row as the row.
    if (cap_reg == 0) cap_eff = 1;
    else if (cap_reg > lfu_pkg::ENTRIES) cap_eff = lfu_pkg::ENTRIES;
    else cap_eff = int'(cap_reg);

    // Scan: first matching key, lowest free slot and the least frequently
    // used slot, ties broken by the older stamp and then the lower index.
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      if (slot_used[i]) begin
        occupied++;
        if (!hit && slot_key[i] == key) begin
          hit = 1'b1;
          found = i;
        end
        if (!have_victim || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_stamp[i] < slot_stamp[victim])) begin
          victim = i;
          have_victim = 1'b1;
        end
      end else if (!have_free) begin
        free_idx = i;
        have_free = 1'b1;
      end
    end

    if (!is_set) begin
      if (hit) begin
        note_use(found);
        r.read_value = slot_val[found];
      end else begin
        r.read_value = lfu_pkg::MISS_VALUE;
      end
    end else if (hit) begin
      slot_val[found] = val;
      note_use(found);
    end else begin
      // A miss evicts exactly one slot once occupancy has reached the
      // capacity, even if a lowered capacity leaves the store over-full.
      if ((occupied >= cap_eff || !have_free) && have_victim) begin
        r.evicted = 1'b1;
        r.evicted_key = slot_key[victim];
        target = victim;
      end else begin
        target = free_idx;
      end
      slot_used[target]  = 1'b1;
      slot_key[target]   = key;
      slot_val[target]   = val;
      slot_uses[target]  = lfu_pkg::COUNT_W'(1);
      slot_stamp[target] = tick_now;
    end
    r.hit = hit;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Response side: ready pattern, the long hold and the checker.
  // --------------------------------------------------------------------------

  // The long hold counts down in its own process once hold_start pulses.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && !hold_start &&
                      ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic note_mismatch(input string what, input logic [lfu_pkg::DATA_W-1:0] want,
                               input logic [lfu_pkg::DATA_W-1:0] got);
    if (mismatch_count < 10) begin
      $display("response %0d: %s mismatch, expected %h, got %h", rsp_seen, what, want, got);
    end
    mismatch_count++;
  endtask

  // Every accepted response word is compared with the oldest prediction.
  always @(posedge clk) begin : check_responses
    access_result_t want;
    access_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{hit: rsp_ch.hit, read_value: rsp_ch.read_value,
              evicted: rsp_ch.evicted, evicted_key: rsp_ch.evicted_key};
      if (due_responses.size() == 0) begin
        note_mismatch("unexpected word", '0, got.read_value);
      end else begin
        want = due_responses.pop_front();
        if (got.hit !== want.hit)
          note_mismatch("hit", lfu_pkg::DATA_W'(want.hit), lfu_pkg::DATA_W'(got.hit));
        if (got.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, got.read_value);
        if (got.evicted !== want.evicted)
          note_mismatch("evicted", lfu_pkg::DATA_W'(want.evicted),
                        lfu_pkg::DATA_W'(got.evicted));
        if (got.evicted_key !== want.evicted_key)
          note_mismatch("evicted_key", want.evicted_key, got.evicted_key);
      end
      rsp_seen++;
    end
  end

  // Watchdog: a hung store ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side helpers. All of them are entered at a rising edge and leave
  // at a rising edge, so every drive is a single nonblocking assignment.
  // --------------------------------------------------------------------------

  // Offer one request word after a random gap, wait for it to be taken and
  // record the response it should cause. Valid is left high so that the next
  // word can follow back to back.
  task automatic send_word(input req_op_t op, input logic [lfu_pkg::DATA_W-1:0] key,
                           input logic [lfu_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= op;
    req_ch.req_key     <= key;
    req_ch.write_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    due_responses.push_back(lfu_access(op == OP_SET, key, val));
  endtask

  // Stop offering, wait for every outstanding response and then let the
  // pipeline settle so the store is idle.
  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // Only ever called while the store is idle.
  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    cap_reg = cap;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // Mostly keys from a small pool so that gets hit and sets overwrite, with
  // the odd fully random key to toggle every bit.
  task automatic send_random_word(input int key_span);
    logic [lfu_pkg::DATA_W-1:0] key;
    if ($urandom_range(9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(key_span - 1)];
    send_word($urandom_range(1) ? OP_SET : OP_GET, key, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Gets and sets with the extreme keys and values at the reset capacity:
  // a miss on an empty store, inserts, hits, an overwrite, and a stored
  // value of all ones that must still read back as a hit.
  task automatic test_basic_ops();
    set_idling(0, 0);
    send_word(OP_GET, KEY_MIN, 32'h0);
    send_word(OP_SET, KEY_MIN, KEY_MAX);
    send_word(OP_SET, KEY_MAX, KEY_MIN);
    send_word(OP_GET, KEY_MIN, 32'hFFFF_FFFF);
    send_word(OP_GET, KEY_MAX, 32'h0);
    send_word(OP_SET, KEY_MIN, 32'h0);
    send_word(OP_GET, KEY_ONES, 32'h0);
    send_word(OP_SET, KEY_ONES, 32'hFFFF_FFFF);
    send_word(OP_GET, KEY_ONES, 32'h0);
    wait_all_answered();
  endtask

  // A capacity of zero behaves as one, below the three slots already held:
  // each set miss evicts exactly one slot, the first by the older stamp on a
  // count tie, and hits never evict.
  task automatic test_capacity_floor();
    write_capacity(5'd0);
    send_word(OP_SET, 32'h0, 32'h1234_5678);
    send_word(OP_GET, 32'h0, 32'h0);
    send_word(OP_SET, 32'h1, 32'hA5A5_A5A5);
    send_word(OP_GET, KEY_ONES, 32'h0);
    send_word(OP_GET, KEY_MIN, 32'h0);
    wait_all_answered();
  endtask

  // With a capacity of two the least used slot goes first, and a key
  // inserted into an evicted slot is found again.
  task automatic test_lfu_order();
    write_capacity(5'd2);
    send_word(OP_SET, 32'h2, 32'h0000_0002);
    send_word(OP_SET, 32'h2, 32'h0000_0022);
    send_word(OP_GET, 32'h2, 32'h0);
    send_word(OP_SET, 32'h3, 32'h0000_0003);
    send_word(OP_GET, 32'h3, 32'h0);
    wait_all_answered();
  endtask

  // A phase of random traffic at one capacity and one idling pattern.
  task automatic test_random_traffic(input logic [lfu_pkg::CAP_W-1:0] cap,
                                     input int src_pct, input int sink_pct,
                                     input int words, input int key_span);
    write_capacity(cap);
    set_idling(src_pct, sink_pct);
    for (int n = 0; n < words; n++) send_random_word(key_span);
    wait_all_answered();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the store fills up and has to stall its request channel.
  task automatic test_backpressure();
    write_capacity(5'd8);
    set_idling(0, 0);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int n = 0; n < 30; n++) send_random_word(12);
    wait_all_answered();
  endtask

  // The sender goes quiet until every response is back, then resumes on the
  // same contents.
  task automatic test_pause_and_resume();
    set_idling(0, 26);
    for (int n = 0; n < 12; n++) send_random_word(12);
    wait_all_answered();
    for (int n = 0; n < 12; n++) send_random_word(12);
    wait_all_answered();
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.req_type    = OP_GET;
    req_ch.req_key     = '0;
    req_ch.write_value = '0;
    cfg_write_en       = 1'b0;
    cfg_write_data     = '0;

    // Predicted state after reset.
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    tick_now = '0;
    cap_reg  = lfu_pkg::CAP_RESET;

    // The pool starts with the extreme keys; the rest is random.
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_ONES;
    key_pool[3] = 32'h0;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_capacity_floor();
    test_lfu_order();
    test_random_traffic(lfu_pkg::CAP_RESET, 0, 0, 250, 24);
    test_random_traffic(5'd31, 70, 0, 200, 32);
    test_random_traffic(5'd1, 0, 70, 150, 4);
    test_random_traffic(5'd5, 26, 26, 250, 10);
    test_random_traffic(lfu_pkg::CAP_W'($urandom_range(31)), 0, 0, 200, 20);
    test_backpressure();
    test_pause_and_resume();
    test_random_traffic(5'd0, 26, 26, 100, 3);
    test_random_traffic(lfu_pkg::CAP_RESET, 26, 26, 150, 32);

    if (mismatch_count == 0 && due_responses.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
